### design/pte_pkg.sv
// shared types and constants for the trapezoid pulse envelope
`default_nettype none

package pte_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_CMP,
    ST_ELAP,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_ZERO,
    ST_DONE
  } state_t;

  // command codes carried by the func field
  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_TICK  = 2'd1,
    FN_SET   = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  // envelope phases
  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_RISE = 2'd1,
    PH_HIGH = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  // configuration register indexes
  localparam logic [2:0] REG_DUTY_TOP     = 3'd0;
  localparam logic [2:0] REG_DUTY_BOTTOM  = 3'd1;
  localparam logic [2:0] REG_LOW_HOLD_MS  = 3'd2;
  localparam logic [2:0] REG_RISE_MS      = 3'd3;
  localparam logic [2:0] REG_HIGH_HOLD_MS = 3'd4;
  localparam logic [2:0] REG_FALL_MS      = 3'd5;
  localparam logic [2:0] REG_BEGIN_HIGH   = 3'd6;
  localparam logic [2:0] REG_PULSE_COUNT  = 3'd7;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // shift-add multiply over the 8-bit level difference, then a restoring
  // divide of the 24-bit product
  localparam int MulSteps = 8;
  localparam int DivSteps = 24;
  localparam int ProdW    = 24;
  localparam int CntW     = 5;

endpackage : pte_pkg

`default_nettype wire

### design/pwm_trapezoid_pulse_envelope.sv
// trapezoid pulse envelope generator for a pwm duty output
//
// Every input beat (func, now_ms, level) produces exactly one output beat
// (duty, pulsing, phase) showing the state after the command. A start command
// arms a repeating low hold / rise / high hold / fall envelope, an update
// tick advances it using the millisecond timestamp, a set command drives a
// fixed duty and stops pulsing. The first hold after a start lasts twice its
// programmed time. Ramps drive bottom + floor(e * (top - bottom) / span).
// One beat is handled at a time. Start, set and idle commands pass from the
// dispatch state straight to the done state, a tick while the envelope is
// stopped or out of pulses passes the zero state on the way, a tick that only
// holds a level or changes phase also the compare and elapsed states, and a
// tick inside a ramp in addition an 8-step shift-add multiply followed by a
// 24-step restoring divide and the finish state. in_stall is high from accept
// until the result is loaded into the output register, so the next beat is
// taken in the cycle after that load at the earliest; a stalled output beat
// holds the next result back but the one waiting is never overwritten.
// Configuration writes are taken on any cycle and should only be issued
// while the block is idle.
// DUTY_BITS sets the saturation limit 2^DUTY_BITS-1 applied to every duty.
`default_nettype none

module pwm_trapezoid_pulse_envelope #(
  parameter int DUTY_BITS = 8
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // configuration write port
  input  wire                           cfg_we,
  input  wire  [pte_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire  [pte_pkg::CfgDataW-1:0]  cfg_wdata,
  // input channel
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [1:0]                    in_func,
  input  wire  [31:0]                   in_now_ms,
  input  wire  [7:0]                    in_level,
  // result channel
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [7:0]                    out_duty,
  output logic                          out_pulsing,
  output logic [1:0]                    out_phase
);

  import pte_pkg::*;

  // saturation limit for every duty driven
  localparam logic [16:0] DutyMax = 17'((1 << DUTY_BITS) - 1);

  function automatic logic [7:0] sat_duty(input logic [7:0] v);
    if ({9'd0, v} > DutyMax) begin
      sat_duty = DutyMax[7:0];
    end else begin
      sat_duty = v;
    end
  endfunction

  // configuration registers
  logic [7:0]  duty_top_r, duty_bottom_r;
  logic [15:0] low_hold_r, rise_r, high_hold_r, fall_r;
  logic        begin_high_r;
  logic [7:0]  pulse_count_r;

  // envelope state
  phase_t      phase_r, phase_nxt;
  logic [31:0] pstart_r, pstart_nxt;
  logic [7:0]  cyc_r, cyc_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  duty_r, duty_nxt;

  // sequencer and captured beat
  state_t      state_r, state_nxt;
  func_t       func_r;
  logic [31:0] now_r;
  logic [7:0]  level_r;

  // working registers of the shared arithmetic unit
  logic [15:0]     span_r, span_nxt;     // duration of the current phase
  logic            lt_r, lt_nxt;         // now before end of phase
  logic            ge_r, ge_nxt;         // now at or after phase start
  logic [31:0]     delta_r, delta_nxt;   // now - phase start
  logic [ProdW-1:0] acc_r, acc_nxt;      // product, then dividend/quotient
  logic [ProdW-1:0] mcand_r, mcand_nxt;  // shifted elapsed (in a fall, remaining) time
  logic [7:0]      mag_r, mag_nxt;       // |top - bottom|, shifted out
  logic            neg_r, neg_nxt;       // top below bottom
  logic [15:0]     rem_r, rem_nxt;       // divide remainder
  logic [CntW-1:0] cnt_r, cnt_nxt;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_duty_r;
  logic        out_pulsing_r;
  logic [1:0]  out_phase_r;

  logic in_acc;
  logic out_load;

  // shared unit operands
  logic [15:0] divisor;
  logic [17:0] trial;
  logic [15:0] e_clamp;
  logic [8:0]  qmag;
  logic [9:0]  ramp_sum;

  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_duty    = out_duty_r;
  assign out_pulsing = out_pulsing_r;
  assign out_phase   = out_phase_r;

  // zero span divides by one so the ramp drives bottom
  assign divisor = (span_r == 16'd0) ? 16'd1 : span_r;
  // one restoring divide step: shift in the next dividend bit and try
  assign trial   = {1'b0, rem_r, acc_r[ProdW-1]} - {2'b00, divisor};

  // elapsed time in the phase, zero before its start, capped at the span
  always_comb begin
    if (!ge_r) begin
      e_clamp = 16'd0;
    end else if (delta_r > {16'd0, span_r}) begin
      e_clamp = span_r;
    end else begin
      e_clamp = delta_r[15:0];
    end
  end

  // floor rounding: a negative quotient with a remainder rounds away from 0
  assign qmag     = acc_r[8:0] + {8'd0, (neg_r && (rem_r != 16'd0))};
  assign ramp_sum = neg_r ? ({2'b00, duty_bottom_r} - {1'b0, qmag})
                          : ({2'b00, duty_bottom_r} + {1'b0, qmag});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (func_r == FN_TICK) begin
          // a tick only moves the envelope while it runs with pulses left
          state_nxt = (run_r && (cyc_r != 8'd0)) ? ST_CMP : ST_ZERO;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CMP:  state_nxt = ST_ELAP;
      ST_ELAP: begin
        if (lt_r && ((phase_r == PH_RISE) || (phase_r == PH_FALL))) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_MUL: begin
        if (cnt_r == CntW'(MulSteps - 1)) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CntW'(DivSteps - 1)) state_nxt = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_ZERO;
      ST_ZERO: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and envelope updates
  always_comb begin
    phase_nxt  = phase_r;
    pstart_nxt = pstart_r;
    cyc_nxt    = cyc_r;
    run_nxt    = run_r;
    duty_nxt   = duty_r;
    span_nxt   = span_r;
    lt_nxt     = lt_r;
    ge_nxt     = ge_r;
    delta_nxt  = delta_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      ST_DISP: begin
        case (func_r)
          FN_START: begin
            run_nxt = 1'b1;
            cyc_nxt = pulse_count_r;
            // phase start lands one hold time ahead, doubling the first hold
            if (begin_high_r) begin
              duty_nxt   = sat_duty(duty_top_r);
              pstart_nxt = now_r + {16'd0, high_hold_r};
              phase_nxt  = PH_HIGH;
            end else begin
              duty_nxt   = sat_duty(duty_bottom_r);
              pstart_nxt = now_r + {16'd0, low_hold_r};
              phase_nxt  = PH_LOW;
            end
          end
          FN_SET: begin
            run_nxt  = 1'b0;
            duty_nxt = sat_duty(level_r);
          end
          FN_TICK: begin
            case (phase_r)
              PH_LOW:  span_nxt = low_hold_r;
              PH_RISE: span_nxt = rise_r;
              PH_HIGH: span_nxt = high_hold_r;
              PH_FALL: span_nxt = fall_r;
              default: span_nxt = low_hold_r;
            endcase
          end
          default: ;
        endcase
      end
      ST_CMP: begin
        // end of phase wraps modulo 2^32, compare is plain unsigned
        lt_nxt    = now_r < (pstart_r + {16'd0, span_r});
        ge_nxt    = now_r >= pstart_r;
        delta_nxt = now_r - pstart_r;
      end
      ST_ELAP: begin
        if (!lt_r) begin
          // phase over: advance, duty holds
          if ((phase_r == PH_FALL) && !cyc_r[7] && (cyc_r != 8'd0)) begin
            cyc_nxt = cyc_r - 8'd1;
          end
          phase_nxt  = phase_t'(phase_r + 2'd1);
          pstart_nxt = now_r;
        end else begin
          case (phase_r)
            PH_LOW:  duty_nxt = sat_duty(duty_bottom_r);
            PH_HIGH: duty_nxt = sat_duty(duty_top_r);
            default: begin
              // a fall counts the time remaining
              mcand_nxt = (phase_r == PH_FALL) ? {8'd0, span_r - e_clamp}
                                               : {8'd0, e_clamp};
              neg_nxt   = duty_top_r < duty_bottom_r;
              mag_nxt   = (duty_top_r < duty_bottom_r) ? (duty_bottom_r - duty_top_r)
                                                       : (duty_top_r - duty_bottom_r);
              acc_nxt   = '0;
              cnt_nxt   = '0;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (mag_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt = {mcand_r[ProdW-2:0], 1'b0};
        mag_nxt   = {1'b0, mag_r[7:1]};
        if (cnt_r == CntW'(MulSteps - 1)) begin
          cnt_nxt = '0;
          rem_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + CntW'(1);
        end
      end
      ST_DIV: begin
        if (!trial[17]) begin
          rem_nxt = trial[15:0];
          acc_nxt = {acc_r[ProdW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[14:0], acc_r[ProdW-1]};
          acc_nxt = {acc_r[ProdW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CntW'(1);
      end
      ST_FIN: begin
        // result lies between top and bottom before saturation
        duty_nxt = sat_duty(ramp_sum[7:0]);
      end
      ST_ZERO: begin
        // an exhausted pulse count stops the envelope and blanks the output
        if (cyc_r == 8'd0) begin
          run_nxt  = 1'b0;
          duty_nxt = 8'd0;
        end
      end
      default: ;
    endcase
  end

  // sequencer and envelope registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_LOW;
      pstart_r <= 32'd0;
      cyc_r    <= 8'hFF;
      run_r    <= 1'b0;
      duty_r   <= 8'd0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      pstart_r <= pstart_nxt;
      cyc_r    <= cyc_nxt;
      run_r    <= run_nxt;
      duty_r   <= duty_nxt;
    end
  end

  // captured beat and working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= func_t'(in_func);
      now_r   <= in_now_ms;
      level_r <= in_level;
    end
    span_r  <= span_nxt;
    lt_r    <= lt_nxt;
    ge_r    <= ge_nxt;
    delta_r <= delta_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  // output register: load when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_duty_r    <= duty_r;
      out_pulsing_r <= run_r;
      out_phase_r   <= phase_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_top_r    <= 8'd255;
      duty_bottom_r <= 8'd0;
      low_hold_r    <= 16'd5;
      rise_r        <= 16'd0;
      high_hold_r   <= 16'd5;
      fall_r        <= 16'd0;
      begin_high_r  <= 1'b0;
      pulse_count_r <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DUTY_TOP:     duty_top_r    <= cfg_wdata[7:0];
        REG_DUTY_BOTTOM:  duty_bottom_r <= cfg_wdata[7:0];
        REG_LOW_HOLD_MS:  low_hold_r    <= cfg_wdata;
        REG_RISE_MS:      rise_r        <= cfg_wdata;
        REG_HIGH_HOLD_MS: high_hold_r   <= cfg_wdata;
        REG_FALL_MS:      fall_r        <= cfg_wdata;
        REG_BEGIN_HIGH:   begin_high_r  <= cfg_wdata[0];
        REG_PULSE_COUNT:  pulse_count_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule : pwm_trapezoid_pulse_envelope

`default_nettype wire
